[hw/rtl/asoa_pkg.sv]
`timescale 1ns / 1ps

package asoa_pkg;

    // averaging and storage sizes
    localparam int SAMPLE_SHIFT = 4;
    localparam int SLOTS        = 8;

    // field widths
    localparam int SAMPLE_W  = 10;
    localparam int AVG_W     = 10;
    localparam int SLOT_W    = 3;
    localparam int MUX_W     = 5;
    localparam int CNT_W     = 7;
    localparam int SUM_W     = 16;
    localparam int SCOUNT_W  = 4;
    localparam int CHLIST_W  = 40;
    localparam int CFG_IDX_W = 1;

    // samples summed per average
    localparam int OSR = 1 << SAMPLE_SHIFT;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LIST = 1'b1;

    // write of one slot average into the store
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] slot;
        logic [AVG_W-1:0]  value;
    } store_wr_t;

endpackage

[hw/rtl/asoa_avg_store.sv]
`timescale 1ns / 1ps

module asoa_avg_store
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  asoa_pkg::store_wr_t            wr,
    input  logic [asoa_pkg::SLOT_W-1:0]    read_slot,
    output logic [asoa_pkg::AVG_W-1:0]     read_value
);

    logic [asoa_pkg::AVG_W-1:0] avg_reg [asoa_pkg::SLOTS];

    // per-slot average registers, zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < asoa_pkg::SLOTS; i++)
            begin
                avg_reg[i] <= '0;
            end
        end
        else if (wr.we)
        begin
            avg_reg[wr.slot] <= wr.value;
        end
    end

    // slots outside the store read as zero
    always_comb
    begin
        if ({1'b0, read_slot} < (asoa_pkg::SLOT_W + 1)'(asoa_pkg::SLOTS))
        begin
            read_value = avg_reg[read_slot];
        end
        else
        begin
            read_value = '0;
        end
    end

endmodule

[hw/rtl/asoa_accum.sv]
`timescale 1ns / 1ps

module asoa_accum
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             step,
    input  logic                             is_sample,
    input  logic [asoa_pkg::SAMPLE_W-1:0]    sample,
    input  logic [asoa_pkg::SCOUNT_W-1:0]    slot_count,
    input  logic [asoa_pkg::CHLIST_W-1:0]    channel_list,
    output asoa_pkg::store_wr_t              wr,
    output logic [asoa_pkg::MUX_W-1:0]       mux_channel,
    output logic                             average_done,
    output logic [asoa_pkg::SLOT_W-1:0]      done_slot
);

    logic [asoa_pkg::SLOT_W-1:0]   slot_reg;
    logic [asoa_pkg::SLOT_W-1:0]   slot_next;
    logic [asoa_pkg::CNT_W-1:0]    cnt_reg;
    logic [asoa_pkg::CNT_W-1:0]    cnt_next;
    logic [asoa_pkg::SUM_W-1:0]    sum_reg;
    logic [asoa_pkg::SUM_W-1:0]    sum_next;
    logic [asoa_pkg::SCOUNT_W-1:0] eff_count;
    logic [asoa_pkg::SCOUNT_W-1:0] slot_inc;
    logic [asoa_pkg::SLOT_W-1:0]   slot_adv;
    logic                          filling;
    logic                          finish;

    // clamp slot count into one..SLOTS
    always_comb
    begin
        if (slot_count == '0)
        begin
            eff_count = asoa_pkg::SCOUNT_W'(1);
        end
        else if (slot_count > asoa_pkg::SCOUNT_W'(asoa_pkg::SLOTS))
        begin
            eff_count = asoa_pkg::SCOUNT_W'(asoa_pkg::SLOTS);
        end
        else
        begin
            eff_count = slot_count;
        end
    end

    // round-robin advance, wraps after the last scanned slot
    assign slot_inc = {1'b0, slot_reg} + asoa_pkg::SCOUNT_W'(1);
    assign slot_adv = (slot_inc < eff_count) ? slot_inc[asoa_pkg::SLOT_W-1:0] : '0;

    assign filling = cnt_reg < asoa_pkg::CNT_W'(asoa_pkg::OSR);
    assign finish  = is_sample && !filling;

    // next state of the sequencer for this item
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        if (is_sample)
        begin
            if (filling)
            begin
                cnt_next = cnt_reg + asoa_pkg::CNT_W'(1);
                sum_next = sum_reg + asoa_pkg::SUM_W'(sample);
            end
            else
            begin
                cnt_next  = '0;
                sum_next  = '0;
                slot_next = slot_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end
        else if (step)
        begin
            slot_reg <= slot_next;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
        end
    end

    // store the mean of the finished slot
    assign wr.we    = step && finish;
    assign wr.slot  = slot_reg;
    assign wr.value = sum_reg[asoa_pkg::SAMPLE_SHIFT +: asoa_pkg::AVG_W];

    // result fields, channel shown is the one after any advance
    assign mux_channel  = channel_list[asoa_pkg::MUX_W * int'(slot_next) +: asoa_pkg::MUX_W];
    assign average_done = finish;
    assign done_slot    = finish ? slot_reg : '0;

endmodule

[hw/rtl/adc_scan_oversample_averager.sv]
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+------------------------------------------------
// in       | in_valid / in_ready    | opcode, sample, read_slot
// out      | out_valid / out_ready  | mux_channel, read_value, average_done, done_slot
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while out_ready is high; an item passes through
// the input register and then the result register
// the sequencer and average store update as an item moves into the result register
// reset clears slot averages, sum, count and current slot; slot_count resets to 1
// a stalled result holds, and the input register takes an item behind it only while empty
// cfg_ready is always high

module adc_scan_oversample_averager
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [asoa_pkg::SAMPLE_W-1:0]     sample,
    input  logic [asoa_pkg::SLOT_W-1:0]       read_slot,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [asoa_pkg::MUX_W-1:0]        mux_channel,
    output logic [asoa_pkg::AVG_W-1:0]        read_value,
    output logic                              average_done,
    output logic [asoa_pkg::SLOT_W-1:0]       done_slot,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [asoa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asoa_pkg::CHLIST_W-1:0]     cfg_data
);

    logic [asoa_pkg::SCOUNT_W-1:0] slot_count_reg;
    logic [asoa_pkg::CHLIST_W-1:0] channel_list_reg;

    logic                          iv_reg;
    logic                          op_reg;
    logic [asoa_pkg::SAMPLE_W-1:0] sample_reg;
    logic [asoa_pkg::SLOT_W-1:0]   rslot_reg;

    logic                          ov_reg;
    logic [asoa_pkg::MUX_W-1:0]    mux_reg;
    logic [asoa_pkg::AVG_W-1:0]    rval_reg;
    logic                          done_reg;
    logic [asoa_pkg::SLOT_W-1:0]   dslot_reg;

    logic                          out_free;
    logic                          move;
    logic                          is_sample;
    asoa_pkg::store_wr_t           wr;
    logic [asoa_pkg::MUX_W-1:0]    mux_c;
    logic                          done_c;
    logic [asoa_pkg::SLOT_W-1:0]   dslot_c;
    logic [asoa_pkg::AVG_W-1:0]    store_rd;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg   <= asoa_pkg::SCOUNT_W'(1);
            channel_list_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                asoa_pkg::REG_SLOT_COUNT:
                begin
                    slot_count_reg <= cfg_data[asoa_pkg::SCOUNT_W-1:0];
                end
                asoa_pkg::REG_CHANNEL_LIST:
                begin
                    channel_list_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign out_free  = !ov_reg || out_ready;
    assign move      = iv_reg && out_free;
    assign in_ready  = !iv_reg || out_free;
    assign is_sample = (op_reg == asoa_pkg::OP_SAMPLE);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg     <= opcode;
            sample_reg <= sample;
            rslot_reg  <= read_slot;
        end
    end

    asoa_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (move),
        .is_sample    (is_sample),
        .sample       (sample_reg),
        .slot_count   (slot_count_reg),
        .channel_list (channel_list_reg),
        .wr           (wr),
        .mux_channel  (mux_c),
        .average_done (done_c),
        .done_slot    (dslot_c)
    );

    asoa_avg_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .read_slot  (rslot_reg),
        .read_value (store_rd)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg <= iv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            mux_reg   <= mux_c;
            rval_reg  <= is_sample ? '0 : store_rd;
            done_reg  <= done_c;
            dslot_reg <= dslot_c;
        end
    end

    assign out_valid    = ov_reg;
    assign mux_channel  = mux_reg;
    assign read_value   = rval_reg;
    assign average_done = done_reg;
    assign done_slot    = dslot_reg;

endmodule

[hw/rtl/asoa_checker.sv]
`timescale 1ns / 1ps

module asoa_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [asoa_pkg::MUX_W-1:0]     mux_channel,
    input  logic [asoa_pkg::AVG_W-1:0]     read_value,
    input  logic                           average_done,
    input  logic [asoa_pkg::SLOT_W-1:0]    done_slot
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mux_channel)
            && $stable(read_value) && $stable(average_done) && $stable(done_slot))
        else $error("result changed while stalled");

    // an accepted item is followed by out_valid once it has passed the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 out_valid)
        else $error("accepted item produced no result");

    // a completed average never carries a read value
    a_read_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_value != '0 |-> !average_done)
        else $error("read value on a completed average");

    // done slot is zero unless an average completed
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !average_done |-> done_slot == '0)
        else $error("done slot set without completed average");

endmodule

bind adc_scan_oversample_averager asoa_checker u_asoa_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mux_channel  (mux_channel),
    .read_value   (read_value),
    .average_done (average_done),
    .done_slot    (done_slot)
);
